// File: rtl/core/c2c_pkg.sv
package c2c_pkg;

  localparam int unsigned RowW   = 17;
  localparam int unsigned ColW   = 11;
  localparam int unsigned ValW   = 64;
  localparam int unsigned IdxW   = 12;
  localparam int unsigned PtrW   = 13;
  localparam int unsigned StatW  = 3;
  localparam int unsigned OpW    = 2;
  localparam int unsigned CntW   = 13;
  localparam int unsigned NnzAw  = 12;
  localparam int unsigned PtrAw  = 11;
  localparam int unsigned FillAw = 10;

  localparam int unsigned MaxNonzeros = 4096;
  localparam int unsigned MaxColumns  = 1024;
  localparam int unsigned PtrDepth    = MaxColumns + 1;

  localparam logic [CntW-1:0] NnzFull = CntW'(MaxNonzeros);
  localparam logic [ColW-1:0] ColMax  = ColW'(MaxColumns);

  localparam logic [OpW-1:0] OP_LOAD  = 2'd0;
  localparam logic [OpW-1:0] OP_PTR   = 2'd1;
  localparam logic [OpW-1:0] OP_ENTRY = 2'd2;
  localparam logic [OpW-1:0] OP_CLEAR = 2'd3;

  localparam logic [StatW-1:0] ST_OK        = 3'd0;
  localparam logic [StatW-1:0] ST_BAD_BASE  = 3'd1;
  localparam logic [StatW-1:0] ST_RANGE     = 3'd2;
  localparam logic [StatW-1:0] ST_OVERFLOW  = 3'd3;
  localparam logic [StatW-1:0] ST_NOT_READY = 3'd4;

  typedef enum logic [3:0] {
    S_IDLE, S_RD_WAIT, S_BASE, S_CHK_RD, S_CHK_EV, S_CLR, S_CNT_COL, S_CNT_RD,
    S_CNT_WR, S_SUM_RD, S_SUM_WR, S_SCT_RD, S_SCT_COL, S_SCT_WR, S_RESP
  } state_e;

  typedef enum logic [3:0] {
    STEP_NONE, STEP_ACCEPT, STEP_RD_CAP, STEP_BASE, STEP_CHK_RD, STEP_CHK_EV,
    STEP_CLR, STEP_CNT_COL, STEP_CNT_RD, STEP_CNT_WR, STEP_SUM_RD, STEP_SUM_WR,
    STEP_SCT_RD, STEP_SCT_COL, STEP_SCT_WR
  } step_e;

  typedef struct packed {
    step_e step;
  } cmd_t;

  typedef struct packed {
    logic conv_start;
    logic read_pend;
    logic base_bad;
    logic range_bad;
    logic at_count;
    logic at_last;
    logic at_ncol;
  } stat_t;

endpackage

// File: rtl/core/c2c_ctrl.sv
module c2c_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          out_ready_i,
  input  c2c_pkg::stat_t stat_i,
  output c2c_pkg::cmd_t  cmd_o,
  output logic          in_ready_o,
  output logic          out_valid_o
);

  c2c_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= c2c_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      c2c_pkg::S_IDLE: begin
        if (in_valid_i) begin
          if (stat_i.conv_start)     state_d = c2c_pkg::S_BASE;
          else if (stat_i.read_pend) state_d = c2c_pkg::S_RD_WAIT;
          else                       state_d = c2c_pkg::S_RESP;
        end
      end
      c2c_pkg::S_RD_WAIT: state_d = c2c_pkg::S_RESP;
      c2c_pkg::S_BASE: begin
        state_d = stat_i.base_bad ? c2c_pkg::S_RESP : c2c_pkg::S_CHK_RD;
      end
      c2c_pkg::S_CHK_RD: state_d = c2c_pkg::S_CHK_EV;
      c2c_pkg::S_CHK_EV: begin
        if (stat_i.range_bad)     state_d = c2c_pkg::S_RESP;
        else if (stat_i.at_count) state_d = c2c_pkg::S_CLR;
        else                      state_d = c2c_pkg::S_CHK_RD;
      end
      c2c_pkg::S_CLR: begin
        if (stat_i.at_ncol) state_d = c2c_pkg::S_CNT_COL;
      end
      c2c_pkg::S_CNT_COL: state_d = c2c_pkg::S_CNT_RD;
      c2c_pkg::S_CNT_RD:  state_d = c2c_pkg::S_CNT_WR;
      c2c_pkg::S_CNT_WR: begin
        state_d = stat_i.at_last ? c2c_pkg::S_SUM_RD : c2c_pkg::S_CNT_COL;
      end
      c2c_pkg::S_SUM_RD: state_d = c2c_pkg::S_SUM_WR;
      c2c_pkg::S_SUM_WR: begin
        state_d = stat_i.at_ncol ? c2c_pkg::S_SCT_RD : c2c_pkg::S_SUM_RD;
      end
      c2c_pkg::S_SCT_RD:  state_d = c2c_pkg::S_SCT_COL;
      c2c_pkg::S_SCT_COL: state_d = c2c_pkg::S_SCT_WR;
      c2c_pkg::S_SCT_WR: begin
        state_d = stat_i.at_last ? c2c_pkg::S_RESP : c2c_pkg::S_SCT_RD;
      end
      c2c_pkg::S_RESP: begin
        if (out_ready_i) state_d = c2c_pkg::S_IDLE;
      end
      default: state_d = c2c_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o  = (state_q == c2c_pkg::S_IDLE);
    out_valid_o = (state_q == c2c_pkg::S_RESP);
    unique case (state_q)
      c2c_pkg::S_IDLE:    cmd_o.step = in_valid_i ? c2c_pkg::STEP_ACCEPT : c2c_pkg::STEP_NONE;
      c2c_pkg::S_RD_WAIT: cmd_o.step = c2c_pkg::STEP_RD_CAP;
      c2c_pkg::S_BASE:    cmd_o.step = c2c_pkg::STEP_BASE;
      c2c_pkg::S_CHK_RD:  cmd_o.step = c2c_pkg::STEP_CHK_RD;
      c2c_pkg::S_CHK_EV:  cmd_o.step = c2c_pkg::STEP_CHK_EV;
      c2c_pkg::S_CLR:     cmd_o.step = c2c_pkg::STEP_CLR;
      c2c_pkg::S_CNT_COL: cmd_o.step = c2c_pkg::STEP_CNT_COL;
      c2c_pkg::S_CNT_RD:  cmd_o.step = c2c_pkg::STEP_CNT_RD;
      c2c_pkg::S_CNT_WR:  cmd_o.step = c2c_pkg::STEP_CNT_WR;
      c2c_pkg::S_SUM_RD:  cmd_o.step = c2c_pkg::STEP_SUM_RD;
      c2c_pkg::S_SUM_WR:  cmd_o.step = c2c_pkg::STEP_SUM_WR;
      c2c_pkg::S_SCT_RD:  cmd_o.step = c2c_pkg::STEP_SCT_RD;
      c2c_pkg::S_SCT_COL: cmd_o.step = c2c_pkg::STEP_SCT_COL;
      c2c_pkg::S_SCT_WR:  cmd_o.step = c2c_pkg::STEP_SCT_WR;
      default:            cmd_o.step = c2c_pkg::STEP_NONE;
    endcase
  end

endmodule

// File: rtl/core/c2c_dp.sv
module c2c_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [c2c_pkg::ColW-1:0]      cfg_wdata_i,
  input  logic [c2c_pkg::OpW-1:0]       op_i,
  input  logic [c2c_pkg::RowW-1:0]      entry_row_i,
  input  logic [c2c_pkg::ColW-1:0]      entry_col_i,
  input  logic [c2c_pkg::ValW-1:0]      entry_value_i,
  input  logic                          last_entry_i,
  input  logic [c2c_pkg::IdxW-1:0]      read_index_i,
  input  c2c_pkg::cmd_t                 cmd_i,
  output c2c_pkg::stat_t                stat_o,
  output logic [c2c_pkg::RowW-1:0]      out_row_o,
  output logic [c2c_pkg::ValW-1:0]      out_value_o,
  output logic [c2c_pkg::PtrW-1:0]      out_pointer_o,
  output logic [c2c_pkg::StatW-1:0]     status_o
);

  // memories
  logic [c2c_pkg::RowW-1:0] load_rows_mem   [c2c_pkg::MaxNonzeros];
  logic [c2c_pkg::ColW-1:0] load_cols_mem   [c2c_pkg::MaxNonzeros];
  logic [c2c_pkg::ValW-1:0] load_values_mem [c2c_pkg::MaxNonzeros];
  logic [c2c_pkg::RowW-1:0] csc_rows_mem    [c2c_pkg::MaxNonzeros];
  logic [c2c_pkg::ValW-1:0] csc_values_mem  [c2c_pkg::MaxNonzeros];
  logic [c2c_pkg::PtrW-1:0] ptr_mem         [c2c_pkg::PtrDepth];
  logic [c2c_pkg::PtrW-1:0] fill_mem        [c2c_pkg::MaxColumns];

  logic [c2c_pkg::RowW-1:0] lrow_rd_q;
  logic [c2c_pkg::ColW-1:0] lcol_rd_q;
  logic [c2c_pkg::ValW-1:0] lval_rd_q;
  logic [c2c_pkg::RowW-1:0] crow_rd_q;
  logic [c2c_pkg::ValW-1:0] cval_rd_q;
  logic [c2c_pkg::PtrW-1:0] ptr_rd_q;
  logic [c2c_pkg::PtrW-1:0] fill_rd_q;

  // control state
  logic [c2c_pkg::CntW-1:0] entry_count_q;
  logic [c2c_pkg::ColW-1:0] min_col_q;
  logic                     converted_q;
  logic [c2c_pkg::ColW-1:0] col_cnt_q;
  logic [c2c_pkg::ColW-1:0] latched_q;

  // conversion working registers
  logic [c2c_pkg::CntW-1:0]  idx_q;
  logic [c2c_pkg::PtrW-1:0]  total_q;
  logic                      inc_q;
  logic [c2c_pkg::ColW-1:0]  ncol_q;
  logic [c2c_pkg::PtrAw-1:0] caddr_q;
  logic [c2c_pkg::OpW-1:0]   op_q;

  logic [c2c_pkg::RowW-1:0]  out_row_q;
  logic [c2c_pkg::ValW-1:0]  out_value_q;
  logic [c2c_pkg::PtrW-1:0]  out_ptr_q;
  logic [c2c_pkg::StatW-1:0] status_q;

  logic                      accept;
  logic [c2c_pkg::CntW-1:0]  eff_count;
  logic [c2c_pkg::ColW-1:0]  eff_min;
  logic                      ovf;
  logic                      load_we;
  logic [c2c_pkg::StatW-1:0] acc_status;
  logic [c2c_pkg::ColW-1:0]  ncol_clamp;
  logic [c2c_pkg::ColW:0]    col_plus;
  logic [c2c_pkg::ColW:0]    col_m1;
  logic [c2c_pkg::PtrAw-1:0] col_addr;
  logic [c2c_pkg::CntW-1:0]  idx_next;

  logic                      ptr_we;
  logic [c2c_pkg::PtrAw-1:0] ptr_waddr;
  logic [c2c_pkg::PtrW-1:0]  ptr_wdata;
  logic [c2c_pkg::PtrAw-1:0] ptr_raddr;
  logic                      fill_we;
  logic [c2c_pkg::FillAw-1:0] fill_waddr;
  logic [c2c_pkg::PtrW-1:0]  fill_wdata;
  logic                      csc_we;

  assign accept    = (cmd_i.step == c2c_pkg::STEP_ACCEPT);
  assign eff_count = converted_q ? '0 : entry_count_q;
  assign eff_min   = converted_q ? '1 : min_col_q;
  assign ovf       = (eff_count == c2c_pkg::NnzFull);
  assign load_we   = accept && (op_i == c2c_pkg::OP_LOAD) && !ovf;
  assign idx_next  = idx_q + c2c_pkg::CntW'(1);

  always_comb begin
    if (col_cnt_q == '0)                   ncol_clamp = c2c_pkg::ColW'(1);
    else if (col_cnt_q > c2c_pkg::ColMax)  ncol_clamp = c2c_pkg::ColMax;
    else                                   ncol_clamp = col_cnt_q;
  end

  assign col_plus = {1'b0, lcol_rd_q} + {{c2c_pkg::ColW{1'b0}}, inc_q};
  assign col_m1   = col_plus - (c2c_pkg::ColW + 1)'(1);
  assign col_addr = col_m1[c2c_pkg::PtrAw-1:0];

  always_comb begin
    acc_status = c2c_pkg::ST_OK;
    unique case (op_i)
      c2c_pkg::OP_LOAD: acc_status = ovf ? c2c_pkg::ST_OVERFLOW : c2c_pkg::ST_OK;
      c2c_pkg::OP_PTR: begin
        if (!converted_q) acc_status = c2c_pkg::ST_NOT_READY;
        else if (read_index_i > {1'b0, latched_q}) acc_status = c2c_pkg::ST_RANGE;
      end
      c2c_pkg::OP_ENTRY: begin
        if (!converted_q) acc_status = c2c_pkg::ST_NOT_READY;
        else if ({1'b0, read_index_i} >= entry_count_q) acc_status = c2c_pkg::ST_RANGE;
      end
      default: acc_status = c2c_pkg::ST_OK;
    endcase
  end

  always_comb begin
    stat_o.conv_start = (op_i == c2c_pkg::OP_LOAD) && !ovf && last_entry_i;
    stat_o.read_pend  = ((op_i == c2c_pkg::OP_PTR) || (op_i == c2c_pkg::OP_ENTRY))
                        && (acc_status == c2c_pkg::ST_OK);
    stat_o.base_bad   = (min_col_q > c2c_pkg::ColW'(1));
    stat_o.range_bad  = (col_plus == '0) || (col_plus > {1'b0, ncol_q});
    stat_o.at_count   = (idx_q == entry_count_q);
    stat_o.at_last    = (idx_next == entry_count_q);
    stat_o.at_ncol    = (idx_q == {2'b00, ncol_q});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_count_q <= '0;
      min_col_q     <= '1;
      converted_q   <= 1'b0;
      col_cnt_q     <= c2c_pkg::ColW'(1);
      latched_q     <= c2c_pkg::ColW'(1);
    end else begin
      if (cfg_we_i) col_cnt_q <= cfg_wdata_i;
      if (accept) begin
        if (op_i == c2c_pkg::OP_LOAD) begin
          converted_q <= 1'b0;
          if (!ovf) begin
            entry_count_q <= eff_count + c2c_pkg::CntW'(1);
            min_col_q     <= (entry_col_i < eff_min) ? entry_col_i : eff_min;
          end
        end else if (op_i == c2c_pkg::OP_CLEAR) begin
          entry_count_q <= '0;
          min_col_q     <= '1;
          converted_q   <= 1'b0;
        end
      end
      if ((cmd_i.step == c2c_pkg::STEP_SCT_WR) && stat_o.at_last) begin
        converted_q <= 1'b1;
        latched_q   <= ncol_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (cmd_i.step)
      c2c_pkg::STEP_ACCEPT: begin
        out_row_q   <= '0;
        out_value_q <= '0;
        out_ptr_q   <= '0;
        status_q    <= acc_status;
        op_q        <= op_i;
      end
      c2c_pkg::STEP_RD_CAP: begin
        if (op_q == c2c_pkg::OP_PTR) begin
          out_ptr_q <= ptr_rd_q;
        end else begin
          out_row_q   <= crow_rd_q;
          out_value_q <= cval_rd_q;
        end
      end
      c2c_pkg::STEP_BASE: begin
        inc_q   <= (min_col_q == '0);
        ncol_q  <= ncol_clamp;
        idx_q   <= '0;
        total_q <= c2c_pkg::PtrW'(1);
        if (stat_o.base_bad) status_q <= c2c_pkg::ST_BAD_BASE;
      end
      c2c_pkg::STEP_CHK_RD: idx_q <= idx_next;
      c2c_pkg::STEP_CHK_EV: begin
        if (stat_o.range_bad) status_q <= c2c_pkg::ST_RANGE;
        if (stat_o.at_count) idx_q <= '0;
      end
      c2c_pkg::STEP_CLR:     idx_q <= stat_o.at_ncol ? '0 : idx_next;
      c2c_pkg::STEP_CNT_RD:  caddr_q <= col_addr;
      c2c_pkg::STEP_CNT_WR:  idx_q <= stat_o.at_last ? '0 : idx_next;
      c2c_pkg::STEP_SUM_WR: begin
        total_q <= total_q + ptr_rd_q;
        idx_q   <= stat_o.at_ncol ? '0 : idx_next;
      end
      c2c_pkg::STEP_SCT_COL: caddr_q <= col_addr;
      c2c_pkg::STEP_SCT_WR:  idx_q <= idx_next;
      default: ;
    endcase
  end

  // pointer and offset store ports
  always_comb begin
    ptr_we    = 1'b0;
    ptr_waddr = idx_q[c2c_pkg::PtrAw-1:0];
    ptr_wdata = '0;
    ptr_raddr = idx_q[c2c_pkg::PtrAw-1:0];
    fill_we    = 1'b0;
    fill_waddr = idx_q[c2c_pkg::FillAw-1:0];
    fill_wdata = total_q - c2c_pkg::PtrW'(1);
    unique case (cmd_i.step)
      c2c_pkg::STEP_ACCEPT: ptr_raddr = read_index_i[c2c_pkg::PtrAw-1:0];
      c2c_pkg::STEP_CLR:    ptr_we = 1'b1;
      c2c_pkg::STEP_CNT_RD: ptr_raddr = col_addr;
      c2c_pkg::STEP_CNT_WR: begin
        ptr_we    = 1'b1;
        ptr_waddr = caddr_q;
        ptr_wdata = ptr_rd_q + c2c_pkg::PtrW'(1);
      end
      c2c_pkg::STEP_SUM_WR: begin
        ptr_we    = 1'b1;
        ptr_wdata = total_q;
        fill_we   = !stat_o.at_ncol;
      end
      c2c_pkg::STEP_SCT_WR: begin
        fill_we    = 1'b1;
        fill_waddr = caddr_q[c2c_pkg::FillAw-1:0];
        fill_wdata = fill_rd_q + c2c_pkg::PtrW'(1);
      end
      default: ;
    endcase
  end

  // positions past the store are dropped
  assign csc_we = (cmd_i.step == c2c_pkg::STEP_SCT_WR) && !fill_rd_q[c2c_pkg::PtrW-1];

  always_ff @(posedge clk_i) begin
    if (load_we) begin
      load_rows_mem[eff_count[c2c_pkg::NnzAw-1:0]]   <= entry_row_i;
      load_cols_mem[eff_count[c2c_pkg::NnzAw-1:0]]   <= entry_col_i;
      load_values_mem[eff_count[c2c_pkg::NnzAw-1:0]] <= entry_value_i;
    end
    lrow_rd_q <= load_rows_mem[idx_q[c2c_pkg::NnzAw-1:0]];
    lcol_rd_q <= load_cols_mem[idx_q[c2c_pkg::NnzAw-1:0]];
    lval_rd_q <= load_values_mem[idx_q[c2c_pkg::NnzAw-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (csc_we) begin
      csc_rows_mem[fill_rd_q[c2c_pkg::NnzAw-1:0]] <=
        lrow_rd_q + {{(c2c_pkg::RowW-1){1'b0}}, inc_q};
      csc_values_mem[fill_rd_q[c2c_pkg::NnzAw-1:0]] <= lval_rd_q;
    end
    crow_rd_q <= csc_rows_mem[read_index_i];
    cval_rd_q <= csc_values_mem[read_index_i];
  end

  always_ff @(posedge clk_i) begin
    if (ptr_we) ptr_mem[ptr_waddr] <= ptr_wdata;
    ptr_rd_q <= ptr_mem[ptr_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (fill_we) fill_mem[fill_waddr] <= fill_wdata;
    fill_rd_q <= fill_mem[col_addr[c2c_pkg::FillAw-1:0]];
  end

  assign out_row_o     = out_row_q;
  assign out_value_o   = out_value_q;
  assign out_pointer_o = out_ptr_q;
  assign status_o      = status_q;

endmodule

// File: rtl/core/coo_to_csc_converter.sv
// Coordinate to compressed sparse column converter. Each input transfer carries
// one operation in s_axis_tuser (load entry, read column pointer, read stored
// entry, clear) and answers with exactly one output transfer whose tuser is the
// status. A load or clear is taken in the idle state and answered from the
// response state, which holds the result while the output stalls; an in-range
// column pointer or stored entry read passes a wait state between them for the
// registered read of the store memories; a refused read goes straight there.
// A load with tlast set runs the conversion before answering: for N entries and
// C columns in use, a column check per entry, a clear of C+1 pointers, a count
// (one read-modify-write per entry), a running sum over C+1 pointers and a
// scatter of the N entries, in turn through the single port pair of the pointer
// and offset memories. The column count register is sampled when conversion runs.
module coo_to_csc_converter (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [10:0]   cfg_wdata_i,    // column_count
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  input  logic [103:0]  s_axis_tdata,   // entry_row, entry_col, entry_value, read_index
  input  logic [1:0]    s_axis_tuser,   // op
  input  logic          s_axis_tlast,   // last_entry
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  output logic [95:0]   m_axis_tdata,   // out_row, out_value, out_pointer, zero pad
  output logic [2:0]    m_axis_tuser    // status
);

  c2c_pkg::cmd_t  cmd;
  c2c_pkg::stat_t stat;

  logic [c2c_pkg::RowW-1:0] out_row;
  logic [c2c_pkg::ValW-1:0] out_value;
  logic [c2c_pkg::PtrW-1:0] out_pointer;

  c2c_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .stat_i      (stat),
    .cmd_o       (cmd),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid)
  );

  c2c_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .op_i          (s_axis_tuser),
    .entry_row_i   (s_axis_tdata[16:0]),
    .entry_col_i   (s_axis_tdata[27:17]),
    .entry_value_i (s_axis_tdata[91:28]),
    .last_entry_i  (s_axis_tlast),
    .read_index_i  (s_axis_tdata[103:92]),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .out_row_o     (out_row),
    .out_value_o   (out_value),
    .out_pointer_o (out_pointer),
    .status_o      (m_axis_tuser)
  );

  assign m_axis_tdata = {2'b00, out_pointer, out_value, out_row};

endmodule

// File: rtl/core/c2c_checker.sv
module c2c_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic [1:0]   s_axis_tuser,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [95:0]  m_axis_tdata,
  input logic [2:0]   m_axis_tuser
);

  // one item in flight: never take input while a result is shown
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && m_axis_tvalid))
    else $error("input taken while result pending");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tuser <= c2c_pkg::ST_NOT_READY))
    else $error("unknown status code");

  a_clear_answer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && (s_axis_tuser == c2c_pkg::OP_CLEAR) |=>
      m_axis_tvalid && (m_axis_tuser == c2c_pkg::ST_OK) && (m_axis_tdata == '0))
    else $error("clear not answered with ok");

endmodule

bind coo_to_csc_converter c2c_checker u_c2c_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
